/* hdl/pct_pkg.sv */
// Shared types and constants for the page completion tracker.
// Used by the controller, the datapath, the top level and the checker.
package pct_pkg;

  localparam int ADDR_W = 48;
  localparam int CNT_W  = 13;
  localparam int PIS_W  = 8;
  localparam int KIND_W = 3;
  localparam logic [CNT_W-1:0] COUNT_MAX = 13'd8191;

  // Result kinds
  localparam logic [KIND_W-1:0] K_ACCEPTED = 3'd0;
  localparam logic [KIND_W-1:0] K_DROPPED  = 3'd1;
  localparam logic [KIND_W-1:0] K_RETIRED  = 3'd2;
  localparam logic [KIND_W-1:0] K_LIST     = 3'd3;
  localparam logic [KIND_W-1:0] K_DONE     = 3'd4;
  localparam logic [KIND_W-1:0] K_FULL     = 3'd5;

  // Operations
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_PROBE,
    S_PCHK,
    S_DRAIN,
    S_DCHK
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture the input beat
    logic mod_step;    // one step of the slot residue
    logic rd_slot;     // read the probe slot
    logic probe_next;  // advance the probe
    logic ins_new;     // insert into a free slot
    logic ins_hit;     // insert into the matching slot
    logic emit_full;   // report table full
    logic rd_cursor;   // read the drain slot
    logic drain_next;  // advance the drain cursor
    logic drain_emit;  // return the drained list
    logic drain_done;  // clear the table
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mod_done;
    logic slot_valid;
    logic match;
    logic probe_last;
    logic cursor_end;
    logic cur_valid;
    logic live;
    logic out_free;
  } stat_t;

endpackage

/* hdl/pct_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/pct_ctrl.sv */
// Controller state machine of the page completion tracker.
// Depends on pct_pkg; drives pct_dp through cmd_t and reads stat_t.
module pct_ctrl
  import pct_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_operation,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // Sequence one beat at a time
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_operation == OP_DRAIN) ? S_DRAIN : S_MOD;
        end
      end
      S_MOD: begin
        if (stat.mod_done) begin
          state_nxt = S_PROBE;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_PROBE: begin
        if (!stat.slot_valid) begin
          if (stat.out_free) begin
            cmd.ins_new = 1'b1;
            state_nxt   = S_IDLE;
          end
        end else begin
          cmd.rd_slot = 1'b1;
          state_nxt   = S_PCHK;
        end
      end
      S_PCHK: begin
        priority if (stat.match) begin
          if (stat.out_free) begin
            cmd.ins_hit = 1'b1;
            state_nxt   = S_IDLE;
          end
        end else if (stat.probe_last) begin
          if (stat.out_free) begin
            cmd.emit_full = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = S_PROBE;
        end
      end
      S_DRAIN: begin
        priority if (stat.cursor_end) begin
          if (stat.out_free) begin
            cmd.drain_done = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else if (!stat.cur_valid) begin
          cmd.drain_next = 1'b1;
        end else begin
          cmd.rd_cursor = 1'b1;
          state_nxt     = S_DCHK;
        end
      end
      S_DCHK: begin
        if (stat.live) begin
          if (stat.out_free) begin
            cmd.drain_emit = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            // Keep the drain slot on the read port while the result waits
            cmd.rd_cursor = 1'b1;
          end
        end else begin
          cmd.drain_next = 1'b1;
          state_nxt      = S_DRAIN;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* hdl/pct_dp.sv */
// Datapath of the page completion tracker: slot table, probe and drain
// counters, result register. Depends on pct_pkg and pct_ram.
module pct_dp
  import pct_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  parameter int PAGE_SHIFT    = 12,
  parameter int SEGMENT_SHIFT = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [ADDR_W-1:0] in_object_address,
  input  logic              in_segment_ok,
  input  logic [CNT_W-1:0]  page_capacity,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KIND_W-1:0] out_kind,
  output logic [ADDR_W-1:0] out_page_address,
  output logic [PIS_W-1:0]  out_page_in_segment,
  output logic [ADDR_W-1:0] out_previous_tail,
  output logic [ADDR_W-1:0] out_list_head,
  output logic [ADDR_W-1:0] out_list_tail,
  output logic [CNT_W-1:0]  out_object_count
);

  localparam int IW     = $clog2(TABLE_ENTRIES);
  localparam int CW     = $clog2(TABLE_ENTRIES + 1);
  localparam int PNW    = ADDR_W - PAGE_SHIFT;
  localparam int PSW    = SEGMENT_SHIFT - PAGE_SHIFT;
  localparam int MB     = 6;
  localparam int MSTEPS = (PNW + MB - 1) / MB;
  localparam int PNP    = MSTEPS * MB;
  localparam int MCW    = $clog2(MSTEPS);
  localparam bit POW2   = (TABLE_ENTRIES == (1 << IW));
  // Entry layout: {page number, count, retired, head, tail}
  localparam int EW    = PNW + CNT_W + 1 + 2 * ADDR_W;
  localparam int O_TL  = 0;
  localparam int O_HD  = ADDR_W;
  localparam int O_RT  = 2 * ADDR_W;
  localparam int O_CT  = O_RT + 1;
  localparam int O_PN  = O_CT + CNT_W;

  logic [ADDR_W-1:0]        addr_r;
  logic                     seg_r;
  logic [IW-1:0]            idx_r;
  logic [IW-1:0]            probe_n_r;
  logic [IW-1:0]            rem_r;
  logic [MCW-1:0]           mod_cnt_r;
  logic                     mod_done_r;
  logic [CW-1:0]            cursor_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic                     out_valid_r;

  logic [EW-1:0]     rdata, wdata;
  logic [IW-1:0]     raddr;
  logic              we;
  logic [PNW-1:0]    pn;
  logic [PNP-1:0]    pn_pad;
  logic [MB-1:0]     digit;
  logic [ADDR_W-1:0] page;
  logic [PSW-1:0]    pis_full;
  logic [PIS_W-1:0]  pis8;
  logic [IW:0]       rem_acc;
  logic [IW-1:0]     rem_nxt;
  logic [IW-1:0]     idx_inc;
  logic [IW-1:0]     cur_idx;

  // Entry fields seen by the update
  logic [PNW-1:0]    e_pn;
  logic [CNT_W-1:0]  e_cnt, n_cnt;
  logic              e_ret, retire;
  logic [ADDR_W-1:0] e_head, e_tail, n_head, n_tail, prev;

  assign pn       = addr_r[ADDR_W-1:PAGE_SHIFT];
  assign page     = {pn, {PAGE_SHIFT{1'b0}}};
  assign pis_full = addr_r[SEGMENT_SHIFT-1:PAGE_SHIFT];
  assign pis8     = PIS_W'(ADDR_W'(pis_full));
  assign cur_idx  = cursor_r[IW-1:0];
  assign idx_inc  = (idx_r == IW'(TABLE_ENTRIES - 1)) ? '0 : idx_r + 1'b1;

  // Residue of the page number modulo table size, six bits a cycle
  assign pn_pad = PNP'(pn);
  assign digit  = pn_pad[mod_cnt_r * MB +: MB];
  always_comb begin
    rem_acc = {1'b0, rem_r};
    for (int j = MB - 1; j >= 0; j--) begin
      rem_acc = {rem_acc[IW-1:0], digit[j]};
      if (rem_acc >= (IW + 1)'(TABLE_ENTRIES)) begin
        rem_acc = rem_acc - (IW + 1)'(TABLE_ENTRIES);
      end
    end
    rem_nxt = rem_acc[IW-1:0];
  end

  // Take a fresh entry or the one read back
  assign e_pn   = rdata[O_PN +: PNW];
  always_comb begin
    if (cmd.ins_new) begin
      e_cnt  = '0;
      e_ret  = 1'b0;
      e_head = '0;
      e_tail = '0;
    end else begin
      e_cnt  = rdata[O_CT +: CNT_W];
      e_ret  = rdata[O_RT];
      e_head = rdata[O_HD +: ADDR_W];
      e_tail = rdata[O_TL +: ADDR_W];
    end
    prev   = (e_cnt == '0) ? '0 : e_tail;
    n_head = (e_cnt == '0) ? addr_r : e_head;
    n_tail = addr_r;
    n_cnt  = (e_cnt < COUNT_MAX) ? e_cnt + 1'b1 : e_cnt;
    retire = (n_cnt == page_capacity) && (pis_full != '0) && seg_r;
  end

  // Build the entry to write back
  always_comb begin
    priority if (e_ret) begin
      wdata = {pn, e_cnt, e_ret, e_head, e_tail};
    end else if (retire) begin
      wdata = {pn, n_cnt, 1'b1, {ADDR_W{1'b0}}, {ADDR_W{1'b0}}};
    end else begin
      wdata = {pn, n_cnt, 1'b0, n_head, n_tail};
    end
  end

  assign we    = cmd.ins_new | cmd.ins_hit;
  assign raddr = cmd.rd_cursor ? cur_idx : idx_r;

  pct_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (idx_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Status back to the controller
  always_comb begin
    stat            = '0;
    stat.mod_done   = mod_done_r;
    stat.slot_valid = valid_r[idx_r];
    stat.match      = (e_pn == pn);
    stat.probe_last = (probe_n_r == IW'(TABLE_ENTRIES - 1));
    stat.cursor_end = (cursor_r == CW'(TABLE_ENTRIES));
    stat.cur_valid  = valid_r[cur_idx];
    stat.live       = !rdata[O_RT] && (rdata[O_CT +: CNT_W] != '0);
    stat.out_free   = !out_valid_r || !out_stall;
  end

  // Capture the beat, run the residue, walk the probe
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r    <= in_object_address;
      seg_r     <= in_segment_ok;
      probe_n_r <= '0;
      rem_r     <= '0;
      mod_cnt_r <= MCW'(MSTEPS - 1);
      if (POW2) begin
        idx_r <= in_object_address[PAGE_SHIFT +: IW];
      end
    end else if (cmd.mod_step) begin
      rem_r     <= rem_nxt;
      mod_cnt_r <= mod_cnt_r - 1'b1;
      if (mod_cnt_r == '0) begin
        idx_r <= rem_nxt;
      end
    end else if (cmd.probe_next) begin
      idx_r     <= idx_inc;
      probe_n_r <= probe_n_r + 1'b1;
    end
  end

  // Control state: residue flag, valid bits, drain cursor, result flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_done_r  <= 1'b0;
      valid_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        mod_done_r <= POW2;
      end else if (cmd.mod_step && mod_cnt_r == '0) begin
        mod_done_r <= 1'b1;
      end
      if (cmd.ins_new) begin
        valid_r[idx_r] <= 1'b1;
      end
      if (cmd.drain_done) begin
        valid_r  <= '0;
        cursor_r <= '0;
      end else if (cmd.drain_next || cmd.drain_emit) begin
        cursor_r <= cursor_r + 1'b1;
      end
      if (cmd.ins_new || cmd.ins_hit || cmd.emit_full || cmd.drain_emit ||
          cmd.drain_done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.ins_new || cmd.ins_hit) begin
      out_page_address    <= page;
      out_page_in_segment <= pis8;
      out_list_head       <= '0;
      out_list_tail       <= '0;
      priority if (e_ret) begin
        out_kind          <= K_DROPPED;
        out_previous_tail <= '0;
        out_object_count  <= e_cnt;
      end else if (retire) begin
        out_kind          <= K_RETIRED;
        out_previous_tail <= prev;
        out_object_count  <= n_cnt;
      end else begin
        out_kind          <= K_ACCEPTED;
        out_previous_tail <= prev;
        out_object_count  <= n_cnt;
      end
    end else if (cmd.emit_full) begin
      out_kind            <= K_FULL;
      out_page_address    <= page;
      out_page_in_segment <= '0;
      out_previous_tail   <= '0;
      out_list_head       <= '0;
      out_list_tail       <= '0;
      out_object_count    <= '0;
    end else if (cmd.drain_emit) begin
      out_kind            <= K_LIST;
      out_page_address    <= {e_pn, {PAGE_SHIFT{1'b0}}};
      out_page_in_segment <= '0;
      out_previous_tail   <= '0;
      out_list_head       <= rdata[O_HD +: ADDR_W];
      out_list_tail       <= rdata[O_TL +: ADDR_W];
      out_object_count    <= rdata[O_CT +: CNT_W];
    end else if (cmd.drain_done) begin
      out_kind            <= K_DONE;
      out_page_address    <= '0;
      out_page_in_segment <= '0;
      out_previous_tail   <= '0;
      out_list_head       <= '0;
      out_list_tail       <= '0;
      out_object_count    <= '0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/page_completion_tracker_core.sv */
// Page completion tracker: groups freed objects by page in a linear-probe
// table and retires a page once page_capacity objects of it have arrived,
// if in_segment_ok is set and the page is not the first of its segment. One
// beat is worked at a time. An insert occupies the block longer when it
// matches than when its home slot is free, and longer again for each further
// slot probed; when TABLE_ENTRIES is not a power of two the home slot residue
// is first worked out, six page-number bits at a time. A drain takes the beat,
// then scans slots, an occupied slot taking longer than an empty one, since
// the slot table is a RAM with one write port and one registered read port.
// A result beat may wait in the output register while the next beat is taken
// in; the next result then waits for it.
module page_completion_tracker_core
  import pct_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  parameter int PAGE_SHIFT    = 12,
  parameter int SEGMENT_SHIFT = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  logic [ADDR_W-1:0] in_object_address,
  input  logic              in_segment_ok,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KIND_W-1:0] out_kind,
  output logic [ADDR_W-1:0] out_page_address,
  output logic [PIS_W-1:0]  out_page_in_segment,
  output logic [ADDR_W-1:0] out_previous_tail,
  output logic [ADDR_W-1:0] out_list_head,
  output logic [ADDR_W-1:0] out_list_tail,
  output logic [CNT_W-1:0]  out_object_count,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic REG_CAPACITY = 1'b0;

  logic [CNT_W-1:0] cap_r;
  cmd_t             cmd;
  stat_t            stat;

  // Capacity register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CNT_W'(1);
    end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY &&
                 paddr[1:0] == 2'b00) begin
      cap_r <= pwdata[CNT_W-1:0];
    end
  end
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32 - CNT_W){1'b0}}, cap_r} : '0;

  pct_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  pct_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .PAGE_SHIFT    (PAGE_SHIFT),
    .SEGMENT_SHIFT (SEGMENT_SHIFT)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_object_address   (in_object_address),
    .in_segment_ok       (in_segment_ok),
    .page_capacity       (cap_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_page_address    (out_page_address),
    .out_page_in_segment (out_page_in_segment),
    .out_previous_tail   (out_previous_tail),
    .out_list_head       (out_list_head),
    .out_list_tail       (out_list_tail),
    .out_object_count    (out_object_count)
  );

endmodule

/* hdl/pct_checker.sv */
// Port-level checks for page_completion_tracker_core, bound to the top level.
// Depends on pct_pkg.
module pct_checker
  import pct_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [KIND_W-1:0] out_kind,
  input logic [ADDR_W-1:0] out_page_address,
  input logic [ADDR_W-1:0] out_list_head,
  input logic [CNT_W-1:0]  out_object_count
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind))
    else $error("result beat changed under stall");

  // An accepted beat keeps the block busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // Drain done carries no page and no count
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_DONE |-> out_page_address == '0 &&
      out_object_count == '0)
    else $error("drain done with payload");

  // Table full reports no count and no list
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_FULL |-> out_object_count == '0 &&
      out_list_head == '0)
    else $error("table full with payload");

  // A drained list always holds objects
  a_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_LIST |-> out_object_count != '0)
    else $error("empty page list");

endmodule

bind page_completion_tracker_core pct_checker u_pct_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_kind         (out_kind),
  .out_page_address (out_page_address),
  .out_list_head    (out_list_head),
  .out_object_count (out_object_count)
);

/* sim/tb_page_completion_tracker_core.sv */
// Self-checking testbench for page_completion_tracker_core: directed and random
// insert/drain beats with an in-bench predictor. Depends on pct_pkg and the core.
module tb_page_completion_tracker_core;
  import pct_pkg::*;

  localparam int SLOTS       = 256;
  localparam int PG_SHIFT    = 12;
  localparam int IDLE_PCT    = 9;
  localparam int STALL_LIMIT = 20000;
  localparam logic [2:0] REG_PAGE_CAPACITY = 3'd0;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic              seg_ok;
  } beat_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] page;
    logic [PIS_W-1:0]  pis;
    logic [ADDR_W-1:0] prev;
    logic [ADDR_W-1:0] head;
    logic [ADDR_W-1:0] tail;
    logic [CNT_W-1:0]  count;
  } result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_operation = 1'b0;
  logic [ADDR_W-1:0] in_object_address = '0;
  logic              in_segment_ok = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [KIND_W-1:0] out_kind;
  logic [ADDR_W-1:0] out_page_address;
  logic [PIS_W-1:0]  out_page_in_segment;
  logic [ADDR_W-1:0] out_previous_tail;
  logic [ADDR_W-1:0] out_list_head;
  logic [ADDR_W-1:0] out_list_tail;
  logic [CNT_W-1:0]  out_object_count;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  page_completion_tracker_core uut (.*);

  // Predictor state
  logic [CNT_W-1:0]  capacity;
  logic              slot_valid [SLOTS];
  logic [35:0]       slot_page  [SLOTS];
  logic [CNT_W-1:0]  slot_count [SLOTS];
  logic              slot_retired [SLOTS];
  logic [ADDR_W-1:0] slot_head  [SLOTS];
  logic [ADDR_W-1:0] slot_tail  [SLOTS];
  int unsigned       cursor;

  beat_t   pending_q[$];
  result_t expected_q[$];
  logic    gaps_on = 1'b1;
  logic    in_taken = 1'b0;
  int      errors = 0;
  int      beats_in = 0;
  int      beats_out = 0;
  int      retired_seen = 0;
  int      full_seen = 0;
  int      lists_seen = 0;
  int      quiet_cycles = 0;
  logic [35:0] pool [20];

  always #4 clk = ~clk;

  // Work out the result of one beat and advance the table copy
  function automatic result_t track_page(beat_t b);
    result_t r;
    logic [35:0] pn;
    logic [CNT_W-1:0] c;
    logic [ADDR_W-1:0] prv;
    int unsigned idx;
    int unsigned hit;
    r = '0;
    if (b.op == OP_DRAIN) begin
      for (int unsigned i = cursor; i < SLOTS; i++) begin
        if (slot_valid[i] && !slot_retired[i] && slot_count[i] != 0) begin
          cursor = i + 1;
          r.kind = K_LIST;
          r.page = {slot_page[i], 12'h000};
          r.head = slot_head[i];
          r.tail = slot_tail[i];
          r.count = slot_count[i];
          return r;
        end
      end
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      cursor = 0;
      r.kind = K_DONE;
      return r;
    end
    pn = b.addr[ADDR_W-1:PG_SHIFT];
    r.page = {pn, 12'h000};
    idx = pn[7:0];
    hit = SLOTS;
    for (int n = 0; n < SLOTS; n++) begin
      if (!slot_valid[idx] || slot_page[idx] == pn) begin
        hit = idx;
        break;
      end
      idx = (idx + 1) % SLOTS;
    end
    if (hit == SLOTS) begin
      r.kind = K_FULL;
      return r;
    end
    r.pis = pn[7:0];
    if (!slot_valid[hit]) begin
      slot_valid[hit] = 1'b1;
      slot_page[hit] = pn;
      slot_count[hit] = '0;
      slot_retired[hit] = 1'b0;
      slot_head[hit] = '0;
      slot_tail[hit] = '0;
    end
    if (slot_retired[hit]) begin
      r.kind = K_DROPPED;
      r.count = slot_count[hit];
      return r;
    end
    c = slot_count[hit];
    prv = (c == 0) ? '0 : slot_tail[hit];
    if (c == 0) slot_head[hit] = b.addr;
    slot_tail[hit] = b.addr;
    if (c < COUNT_MAX) c = c + 1'b1;
    slot_count[hit] = c;
    r.prev = prv;
    r.count = c;
    if (c == capacity && pn[7:0] != 0 && b.seg_ok) begin
      slot_retired[hit] = 1'b1;
      slot_head[hit] = '0;
      slot_tail[hit] = '0;
      r.kind = K_RETIRED;
    end else begin
      r.kind = K_ACCEPTED;
    end
    return r;
  endfunction

  function automatic result_t push_beat(logic op, logic [ADDR_W-1:0] addr, logic seg);
    beat_t b;
    result_t r;
    b.op = op;
    b.addr = addr;
    b.seg_ok = seg;
    r = track_page(b);
    pending_q.push_back(b);
    expected_q.push_back(r);
    return r;
  endfunction

  // Drain until the table reports done
  task automatic drain_all();
    result_t r;
    do r = push_beat(OP_DRAIN, 48'({$urandom, $urandom}), 1'($urandom_range(1)));
    while (r.kind != K_DONE);
  endtask

  task automatic wait_quiet();
    wait (pending_q.size() == 0 && expected_q.size() == 0 && !in_valid);
    repeat (20) @(posedge clk);
  endtask

  // Register write: setup then access phase, held until pready
  task automatic write_capacity(logic [CNT_W-1:0] value);
    wait_quiet();
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_PAGE_CAPACITY;
    pwdata <= {19'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    capacity = value;
  endtask

  function automatic logic [ADDR_W-1:0] in_page(logic [35:0] pn);
    return {pn, 12'(($urandom_range(1) != 0) ? $urandom : 12'hFFF)};
  endfunction

  task automatic random_phase(int n_beats);
    result_t r;
    int sel;
    foreach (pool[i]) begin
      pool[i] = 36'({$urandom, $urandom});
      if ($urandom_range(3) == 0) pool[i][7:0] = 8'h00;
      if (i > 0 && $urandom_range(3) == 0) pool[i][7:0] = pool[i-1][7:0];
    end
    for (int k = 0; k < n_beats; k++) begin
      sel = $urandom_range(99);
      if (sel < 82)
        r = push_beat(OP_INSERT, in_page(pool[$urandom_range(19)]), $urandom_range(9) != 0);
      else if (sel < 92)
        r = push_beat(OP_INSERT, 48'({$urandom, $urandom}), 1'($urandom_range(1)));
      else
        r = push_beat(OP_DRAIN, 48'({$urandom, $urandom}), 1'($urandom_range(1)));
      if (k % 70 == 69) drain_all();
    end
    drain_all();
  endtask

  // Driver: present the next beat at the falling edge
  always @(negedge clk) begin
    beat_t b;
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_q.size() > 0 && !(gaps_on && $urandom_range(99) < IDLE_PCT)) begin
          b = pending_q.pop_front();
          in_valid <= 1'b1;
          in_operation <= b.op;
          in_object_address <= b.addr;
          in_segment_ok <= b.seg_ok;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Monitor: check each result beat against the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t exp_r;
    logic progress;
    in_taken = rst_n && in_valid && !in_stall;
    progress = in_taken;
    if (in_taken) beats_in++;
    if (rst_n && out_valid && !out_stall) begin
      progress = 1'b1;
      beats_out++;
      got = '{out_kind, out_page_address, out_page_in_segment, out_previous_tail,
              out_list_head, out_list_tail, out_object_count};
      if (got.kind == K_RETIRED) retired_seen++;
      if (got.kind == K_FULL) full_seen++;
      if (got.kind == K_LIST) lists_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %p", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got.kind != exp_r.kind || got.page != exp_r.page || got.pis != exp_r.pis ||
            got.prev != exp_r.prev || got.head != exp_r.head || got.tail != exp_r.tail ||
            got.count != exp_r.count) begin
          errors++;
          if (errors <= 10) $display("mismatch at beat %0d\n  exp %p\n  got %p",
                                     beats_out, exp_r, got);
        end
      end
    end
    // Watchdog on handshake progress
    if (progress || !rst_n) quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    result_t r;
    logic [35:0] pn;
    capacity = 13'd1;
    cursor = 0;
    foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: page zero, top address, drop after retire, bad segment, over capacity
    write_capacity(13'd1);
    r = push_beat(OP_INSERT, 48'h0, 1'b1);
    r = push_beat(OP_INSERT, 48'hFFFF_FFFF_FFFF, 1'b1);
    r = push_beat(OP_INSERT, 48'hFFFF_FFFF_F000, 1'b1);
    r = push_beat(OP_INSERT, 48'h0000_0000_1008, 1'b0);
    r = push_beat(OP_INSERT, 48'h0000_0000_1FF0, 1'b1);
    r = push_beat(OP_INSERT, 48'h0000_0000_0FF8, 1'b0);
    drain_all();
    // Insert behind and ahead of the drain cursor
    write_capacity(13'd2);
    r = push_beat(OP_INSERT, 48'h0000_0004_0010, 1'b1);
    r = push_beat(OP_INSERT, 48'h0000_0009_0020, 1'b1);
    r = push_beat(OP_DRAIN, 48'h0, 1'b0);
    r = push_beat(OP_INSERT, 48'h0000_0001_0040, 1'b1);
    r = push_beat(OP_INSERT, 48'h0000_000F_0040, 1'b1);
    r = push_beat(OP_INSERT, 48'h0000_0009_0028, 1'b1);
    drain_all();
    r = push_beat(OP_DRAIN, 48'h0, 1'b1);

    // Capacity zero: the page never retires
    write_capacity(13'd0);
    for (int k = 0; k < 30; k++) r = push_beat(OP_INSERT, in_page(36'h12345_6789), 1'b1);
    drain_all();

    // Larger capacity: one page filled to retirement, then a drop
    write_capacity(13'd64);
    for (int k = 0; k < 65; k++) r = push_beat(OP_INSERT, in_page(36'hA_BCDE_F012), 1'b1);
    drain_all();

    // Fill the table with colliding pages, half retired, then overflow it
    write_capacity(13'd1);
    for (int k = 0; k < SLOTS; k++) begin
      pn = {28'(k), 8'h05};
      r = push_beat(OP_INSERT, in_page(pn), 1'(k));
    end
    r = push_beat(OP_INSERT, {36'hF_FFFF_FF05, 12'h123}, 1'b1);
    r = push_beat(OP_INSERT, {36'h0_0000_0077, 12'h000}, 1'b1);
    r = push_beat(OP_INSERT, {36'h0_0000_0305, 12'h010}, 1'b1);
    drain_all();

    // Random phases across capacities; one stretch without idling
    write_capacity(13'd3);
    random_phase(80);
    write_capacity(13'd1);
    random_phase(60);
    write_capacity(13'd5);
    wait_quiet();
    gaps_on = 1'b0;
    random_phase(80);
    wait_quiet();
    gaps_on = 1'b1;
    write_capacity(13'd2);
    random_phase(60);
    write_capacity(13'($urandom_range(16, 1)));
    random_phase(60);
    write_capacity(13'd4096);
    random_phase(50);

    wait_quiet();
    repeat (100) @(posedge clk);
    $display("covered %0d input beats, %0d results: %0d retired, %0d lists, %0d table full",
             beats_in, beats_out, retired_seen, lists_seen, full_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_q.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
